// ===== sv/tcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsp_pkg: shared types and codes for the two-class slot pool allocator
// Request kinds, status codes, config register indexes, sequencer states.
// ----------------------------------------------------------------------------
package tcsp_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned RECL_W   = 5;
  localparam int unsigned CFG_W    = 32;

  localparam logic [SIZE_W-1:0] THRESH_RESET  = 16'd256;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd60000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BAD_HDL = 2'd2,
    STAT_RSVD    = 2'd3
  } status_e;

  typedef enum logic {
    CFG_SIZE_THRESHOLD = 1'b0,
    CFG_HOLD_TIMEOUT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_REL_RD,
    ST_REL_AGE,
    ST_REL_FIN,
    ST_SWEEP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [TICK_W-1:0] age;
    logic              expired;
  } age_res_t;

endpackage

// ===== sv/two_class_slot_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// two_class_slot_pool_allocator_unit: two-class slot pool with hold timeout
// Normal and extended slots share one stamp memory (normal first); a small
// sequencer drives the memory read port and the shared age unit.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o  | kind_i, size_i, handle_i
//  out     | out_valid_o / out_ready_i| status_o, slot_o, held_ticks_o,
//          |                          | reclaimed_o
//  cfg     | cfg_we_i (no wait)       | cfg_addr_i, cfg_data_i
//
//  Allocate: scans the slots of its class, one slot per cycle, up to the
//  class size. Release: stamp read, then the age unit. Tick: a sweep over
//  every slot, one stamp memory read per cycle with a two-stage age pipeline.
//  Bad handle and unused kind go straight to the result state.
//  Reset frees every slot and clears the tick counter; no clearing pass.
//  A finished beat waits in the output register; the next beat is taken
//  meanwhile, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module two_class_slot_pool_allocator_unit import tcsp_pkg::*; #(
  parameter int unsigned NORMAL_SLOTS = 16,
  parameter int unsigned EXT_SLOTS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SIZE_W-1:0]   size_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o,
  output logic [TICK_W-1:0]   held_ticks_o,
  output logic [RECL_W-1:0]   reclaimed_o,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned TOTAL_SLOTS = NORMAL_SLOTS + EXT_SLOTS;
  localparam int unsigned IDX_W       = $clog2(TOTAL_SLOTS);
  localparam logic [IDX_W-1:0] IDX_NORM_LAST = IDX_W'(NORMAL_SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_EXT_BASE  = IDX_W'(NORMAL_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(TOTAL_SLOTS - 1);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]      thresh_q;
  logic [TICK_W-1:0]      timeout_q;
  logic [TICK_W-1:0]      tick_q;
  logic [TOTAL_SLOTS-1:0] free_q;

  logic [IDX_W-1:0] scan_q, last_q, rel_idx_q;
  logic [IDX_W-1:0] iss_q, p1_idx_q, p2_idx_q;
  logic             iss_done_q, p1_v_q, p2_v_q;

  status_e           res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [TICK_W-1:0] res_held_q;
  logic [RECL_W-1:0] res_recl_q;

  logic              out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TICK_W-1:0] out_held_q;
  logic [RECL_W-1:0] out_recl_q;

  logic              in_fire, out_free, bad_handle, issue;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TICK_W-1:0] ram_rdata;
  age_res_t          age_res;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign bad_handle = (32'(handle_i) >= 32'(TOTAL_SLOTS));
  assign issue      = (state_q == ST_SWEEP) && !iss_done_q;

  tcsp_stamp_ram #(
    .DEPTH  (TOTAL_SLOTS),
    .ADDR_W (IDX_W)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (scan_q),
    .wdata_i (tick_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcsp_age_unit u_age_unit (
    .clk_i     (clk_i),
    .now_i     (tick_q),
    .stamp_i   (ram_rdata),
    .timeout_i (timeout_q),
    .res_o     (age_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind_e'(kind_i))
            KIND_ALLOC:   state_d = ST_ALLOC;
            KIND_RELEASE: state_d = bad_handle ? ST_RESULT : ST_REL_RD;
            KIND_TICK:    state_d = ST_SWEEP;
            KIND_NOP:     state_d = ST_RESULT;
          endcase
        end
      end
      ST_ALLOC: begin
        if (free_q[scan_q] || scan_q == last_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_REL_RD:  state_d = ST_REL_AGE;
      ST_REL_AGE: state_d = ST_REL_FIN;
      ST_REL_FIN: state_d = ST_RESULT;
      ST_SWEEP: begin
        if (iss_done_q && !p1_v_q && !p2_v_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = iss_q;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_ALLOC:  ram_we     = free_q[scan_q];
      ST_REL_RD: ram_raddr  = rel_idx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thresh_q    <= THRESH_RESET;
      timeout_q   <= TIMEOUT_RESET;
      tick_q      <= '0;
      free_q      <= '1;
      iss_done_q  <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_SIZE_THRESHOLD: thresh_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_HOLD_TIMEOUT:   timeout_q <= cfg_data_i[TICK_W-1:0];
        endcase
      end

      if (in_fire && kind_e'(kind_i) == KIND_TICK) begin
        tick_q <= tick_q + 1'b1;
      end

      if (state_q == ST_ALLOC && free_q[scan_q]) begin
        free_q[scan_q] <= 1'b0;
      end
      if (state_q == ST_REL_FIN) begin
        free_q[rel_idx_q] <= 1'b1;
      end

      // sweep pipeline: read issue, stamp out, age out
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      if (in_fire) begin
        iss_done_q <= 1'b0;
      end else if (issue && iss_q == IDX_LAST) begin
        iss_done_q <= 1'b1;
      end
      if (state_q == ST_SWEEP && p2_v_q && age_res.expired && !free_q[p2_idx_q]) begin
        free_q[p2_idx_q] <= 1'b1;
      end

      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and counters, no reset needed
  always_ff @(posedge clk_i) begin
    p1_idx_q <= iss_q;
    p2_idx_q <= p1_idx_q;

    if (in_fire) begin
      res_slot_q   <= '0;
      res_held_q   <= '0;
      res_recl_q   <= '0;
      rel_idx_q    <= IDX_W'(handle_i);
      iss_q        <= '0;
      if (size_i <= thresh_q) begin
        scan_q <= '0;
        last_q <= IDX_NORM_LAST;
      end else begin
        scan_q <= IDX_EXT_BASE;
        last_q <= IDX_LAST;
      end
      if (kind_e'(kind_i) == KIND_RELEASE && bad_handle) begin
        res_status_q <= STAT_BAD_HDL;
      end else begin
        res_status_q <= STAT_OK;
      end
    end else begin
      unique case (state_q)
        ST_ALLOC: begin
          priority if (free_q[scan_q]) begin
            res_slot_q <= SLOT_W'(scan_q);
          end else if (scan_q == last_q) begin
            res_status_q <= STAT_NO_FREE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_REL_FIN: res_held_q <= age_res.age;
        ST_SWEEP: begin
          if (issue && iss_q != IDX_LAST) begin
            iss_q <= iss_q + 1'b1;
          end
          if (p2_v_q && age_res.expired && !free_q[p2_idx_q]) begin
            res_recl_q <= res_recl_q + 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (state_q == ST_RESULT && out_free) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_held_q   <= res_held_q;
      out_recl_q   <= res_recl_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = out_slot_q;
  assign held_ticks_o = out_held_q;
  assign reclaimed_o  = out_recl_q;

endmodule

// ===== sv/tcsp_stamp_ram.sv =====
// ----------------------------------------------------------------------------
// tcsp_stamp_ram: allocation stamp storage
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module tcsp_stamp_ram import tcsp_pkg::*; #(
  parameter int unsigned DEPTH  = 20,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [TICK_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [TICK_W-1:0] rdata_o
);

  logic [TICK_W-1:0] mem_q [DEPTH];
  logic [TICK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcsp_age_unit.sv =====
// ----------------------------------------------------------------------------
// tcsp_age_unit: shared age subtract and timeout compare
// age = now - stamp (mod 2^32); expired when age > timeout. Registered.
// ----------------------------------------------------------------------------
module tcsp_age_unit import tcsp_pkg::*; (
  input  logic              clk_i,
  input  logic [TICK_W-1:0] now_i,
  input  logic [TICK_W-1:0] stamp_i,
  input  logic [TICK_W-1:0] timeout_i,
  output age_res_t          res_o
);

  age_res_t res_d, res_q;

  always_comb begin
    res_d.age     = now_i - stamp_i;
    res_d.expired = (res_d.age > timeout_i);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
